@@ rtl/core/otq_pkg.sv @@
// ----------------------------------------------------------------------------
// otq_pkg
// Types and constants shared by the ordered timer queue.
// ----------------------------------------------------------------------------
package otq_pkg;

    localparam int unsigned NumTimersDefault = 32;
    localparam int unsigned MaxOut           = 32;
    localparam logic [47:0] TimeMax          = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_EXPIRE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_STOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_EXPIRED = 3'd2,
        ST_NONE    = 3'd3,
        ST_WAIT    = 3'd4,
        ST_STOPPED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] now_ms;
        logic [31:0] delay_ms;
        logic        periodic;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  timer_slot;
        logic [47:0] wait_ms;
        logic        queue_empty;
        logic        last;
    } t_out;

endpackage

@@ rtl/core/ordered_timer_queue_core.sv @@
// ----------------------------------------------------------------------------
// ordered_timer_queue_core
// Deadline-ordered timer table held in one synchronous memory.
// ----------------------------------------------------------------------------
// Add, stop: result valid in the cycle after the transfer.
// Query: one scan of the deadline memory, one entry a cycle.
// Expire with k due timers (at most MaxOut emitted): one scan per emitted timer
// plus a final scan; an output stall holds the block in the emit state.
// One item in work at a time; the next transfer waits until the result is taken.
// Synchronous active-low reset clears occupied and periodic marks.
module ordered_timer_queue_core #(
    parameter int unsigned NUM_TIMERS = otq_pkg::NumTimersDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  otq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output otq_pkg::t_out o_data
);
    import otq_pkg::*;

    localparam int unsigned SW = $clog2(NUM_TIMERS);
    localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
    localparam int unsigned OW = $clog2(MaxOut + 1);

    // deadline (48) and period (32) per slot
    logic [79:0] mem [NUM_TIMERS];
    logic [79:0] r_rd;

    logic [NUM_TIMERS-1:0] r_occ, n_occ, r_per, n_per, r_taken, n_taken;
    t_state  r_state, n_state;
    t_in     r_in, n_in;
    t_out    r_out, n_out;
    logic    r_ov, n_ov;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_rdv, n_rdv;
    logic [SW-1:0] r_rslot;
    logic          r_found, n_found;
    logic [SW-1:0] r_best, n_best;
    logic [47:0]   r_bdl, n_bdl;
    logic [OW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_pend, n_pend;
    logic          r_hasp, n_hasp;
    logic          r_keep, n_keep;
    logic [CW-1:0] r_ocnt, n_ocnt;

    logic          we;
    logic [SW-1:0] waddr;
    logic [79:0]   wdata;
    logic [SW-1:0] raddr;

    logic [48:0] sum;
    logic [SW-1:0] free_slot;
    logic        free_any;
    logic [47:0] rdl;
    logic        cand;
    logic [NUM_TIMERS-1:0] occ_after;
    logic        qe_final;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd    <= mem[raddr];
        r_rslot <= raddr;
    end

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign rdl     = r_rd[79:32];

    // table ends empty only if every stored timer is due, one-shot and fits in one expire
    assign qe_final = !r_keep && (32'(r_ocnt) <= MaxOut);

    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_slot = SW'(i);
                free_any  = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_out   = r_out;
        n_ov    = r_ov;
        n_occ   = r_occ;
        n_per   = r_per;
        n_taken = r_taken;
        n_idx   = r_idx;
        n_rdv   = 1'b0;
        n_found = r_found;
        n_best  = r_best;
        n_bdl   = r_bdl;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_hasp  = r_hasp;
        n_keep  = r_keep;
        n_ocnt  = r_ocnt;
        we      = 1'b0;
        waddr   = '0;
        wdata   = '0;
        raddr   = r_idx[SW-1:0];
        sum     = '0;
        cand    = 1'b0;
        occ_after = r_occ;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_in    = i_data;
                    n_taken = '0;
                    n_cnt   = '0;
                    n_hasp  = 1'b0;
                    n_keep  = 1'b0;
                    n_ocnt  = '0;
                    n_out   = '0;
                    case (t_func'(i_data.func))
                        FUNC_ADD: begin
                            sum = {1'b0, i_data.now_ms} + 49'(i_data.delay_ms);
                            n_out.last = 1'b1;
                            if (free_any) begin
                                we    = 1'b1;
                                waddr = free_slot;
                                wdata = {sum[48] ? TimeMax : sum[47:0], i_data.delay_ms};
                                n_occ[free_slot] = 1'b1;
                                n_per[free_slot] = i_data.periodic;
                                n_out.status     = ST_ADDED;
                                n_out.timer_slot = 5'(free_slot);
                            end else begin
                                n_out.status      = ST_FULL;
                                n_out.queue_empty = (r_occ == '0);
                            end
                            n_ov = 1'b1;
                        end
                        FUNC_STOP: begin
                            n_per  = '0;
                            n_out.status      = ST_STOPPED;
                            n_out.queue_empty = (r_occ == '0);
                            n_out.last        = 1'b1;
                            n_ov = 1'b1;
                        end
                        default: begin
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one entry read per cycle, compare the previous read
                if (r_idx < CW'(NUM_TIMERS)) begin
                    n_idx = r_idx + 1'b1;
                    n_rdv = 1'b1;
                end
                if (r_rdv) begin
                    cand = r_occ[r_rslot] && !r_taken[r_rslot];
                    if (r_in.func == FUNC_EXPIRE) begin
                        cand = cand && (rdl <= r_in.now_ms);
                        // first pass: count stored timers and note any that stays
                        if (!r_hasp && r_occ[r_rslot]) begin
                            n_ocnt = r_ocnt + 1'b1;
                            if (rdl > r_in.now_ms || r_per[r_rslot]) begin
                                n_keep = 1'b1;
                            end
                        end
                    end
                    if (cand && (!r_found || rdl < r_bdl)) begin
                        n_found = 1'b1;
                        n_best  = r_rslot;
                        n_bdl   = rdl;
                    end
                end
                if (r_idx == CW'(NUM_TIMERS) && !r_rdv) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // read period of the winner for re-arm
                raddr = r_best;
                if (r_in.func == FUNC_QUERY) begin
                    n_out.status      = ST_WAIT;
                    n_out.queue_empty = !r_found;
                    n_out.wait_ms     = (r_found && r_bdl > r_in.now_ms) ?
                                        r_bdl - r_in.now_ms : '0;
                    n_out.last        = 1'b1;
                    n_state = S_DONE;
                end else if (r_found && r_cnt < OW'(MaxOut)) begin
                    n_taken[r_best] = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EMIT: begin
                // commit the winner; hold the result until the next is known
                raddr = r_best;
                sum = {1'b0, r_in.now_ms} + 49'(r_rd[31:0]);
                if (r_per[r_best]) begin
                    we    = 1'b1;
                    waddr = r_best;
                    wdata = {sum[48] ? TimeMax : sum[47:0], r_rd[31:0]};
                end else begin
                    n_occ[r_best] = 1'b0;
                end
                n_pend  = r_best;
                n_hasp  = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                n_idx   = '0;
                n_found = 1'b0;
                if (r_hasp) begin
                    n_out.status      = ST_EXPIRED;
                    n_out.timer_slot  = 5'(r_pend);
                    n_out.queue_empty = qe_final;
                    n_out.last        = 1'b0;
                    n_ov = 1'b1;
                    n_state = (r_ov && !i_ready) ? S_EMIT : S_SCAN;
                    if (r_ov && !i_ready) begin
                        we = 1'b0;
                        n_occ  = r_occ;
                        n_pend = r_pend;
                        n_cnt  = r_cnt;
                        n_out  = r_out;
                        n_ov   = r_ov;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    occ_after = r_occ;
                    if (r_in.func == FUNC_EXPIRE) begin
                        n_out = '0;
                        n_out.queue_empty = (occ_after == '0);
                        n_out.last        = 1'b1;
                        if (r_hasp) begin
                            n_out.status     = ST_EXPIRED;
                            n_out.timer_slot = 5'(r_pend);
                        end else begin
                            n_out.status = ST_NONE;
                        end
                    end
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_occ   <= '0;
            r_per   <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_occ   <= n_occ;
            r_per   <= n_per;
            r_rdv   <= n_rdv;
        end
        r_in    <= n_in;
        r_out   <= n_out;
        r_taken <= n_taken;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_best  <= n_best;
        r_bdl   <= n_bdl;
        r_cnt   <= n_cnt;
        r_pend  <= n_pend;
        r_hasp  <= n_hasp;
        r_keep  <= n_keep;
        r_ocnt  <= n_ocnt;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered timer queue: directed table, then
// random add/expire/query/stop traffic checked against a timer-table model.
// ----------------------------------------------------------------------------
module tb;
    import otq_pkg::*;

    localparam int NumSlots   = 32;
    localparam int StallLimit = 200000;

    typedef struct {
        t_in  item;
        bit   known;
        t_out res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    ordered_timer_queue_core #(.NUM_TIMERS(NumSlots)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #1 i_clk = ~i_clk;

    // timer table shadow
    logic [47:0] deadline_q [NumSlots];
    logic [31:0] period_q   [NumSlots];
    bit          busy_q     [NumSlots];
    bit          repeat_q   [NumSlots];

    t_out pending_results [$];
    t_out typed_results [$];
    int   errors = 0;
    int   sender_idle = 0;
    int   receiver_stall = 0;
    int   quiet_cycles = 0;

    function automatic logic [47:0] time_sum(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? TimeMax : s[47:0];
    endfunction

    function automatic bit table_is_empty();
        foreach (busy_q[i]) if (busy_q[i]) return 0;
        return 1;
    endfunction

    function automatic t_out mk(t_status st, int slot, logic [47:0] w, bit e, bit l);
        t_out r;
        r.status = st;
        r.timer_slot = slot[4:0];
        r.wait_ms = w;
        r.queue_empty = e;
        r.last = l;
        return r;
    endfunction

    function automatic void expect_result(t_out r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic predict_timers(t_in it);
        int order [$];
        bit taken [NumSlots];
        int best;
        logic [47:0] w;
        bit e;
        case (t_func'(it.func))
            FUNC_ADD: begin
                for (int i = 0; i < NumSlots; i++) begin
                    if (!busy_q[i]) begin
                        busy_q[i] = 1;
                        deadline_q[i] = time_sum(it.now_ms, it.delay_ms);
                        period_q[i] = it.delay_ms;
                        repeat_q[i] = it.periodic;
                        expect_result(mk(ST_ADDED, i, '0, 0, 1));
                        return;
                    end
                end
                expect_result(mk(ST_FULL, 0, '0, table_is_empty(), 1));
            end
            FUNC_EXPIRE: begin
                foreach (taken[i]) taken[i] = 0;
                while (order.size() < MaxOut) begin
                    best = -1;
                    for (int i = 0; i < NumSlots; i++) begin
                        if (!busy_q[i] || taken[i] || deadline_q[i] > it.now_ms) continue;
                        if (best < 0 || deadline_q[i] < deadline_q[best]) best = i;
                    end
                    if (best < 0) break;
                    taken[best] = 1;
                    order.insert(order.size(), best);
                end
                foreach (order[k]) begin
                    if (repeat_q[order[k]])
                        deadline_q[order[k]] = time_sum(it.now_ms, period_q[order[k]]);
                    else
                        busy_q[order[k]] = 0;
                end
                e = table_is_empty();
                if (order.size() == 0)
                    expect_result(mk(ST_NONE, 0, '0, e, 1));
                foreach (order[k])
                    expect_result(mk(ST_EXPIRED, order[k], '0, e, k == order.size() - 1));
            end
            FUNC_QUERY: begin
                best = -1;
                for (int i = 0; i < NumSlots; i++)
                    if (busy_q[i] && (best < 0 || deadline_q[i] < deadline_q[best]))
                        best = i;
                if (best < 0) begin
                    expect_result(mk(ST_WAIT, 0, '0, 1, 1));
                end else begin
                    w = (deadline_q[best] > it.now_ms) ? deadline_q[best] - it.now_ms : '0;
                    expect_result(mk(ST_WAIT, 0, w, 0, 1));
                end
            end
            default: begin
                foreach (repeat_q[i]) repeat_q[i] = 0;
                expect_result(mk(ST_STOPPED, 0, '0, table_is_empty(), 1));
            end
        endcase
    endtask

    // result check at the rising edge
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d slot=%0d", o_data.status,
                       o_data.timer_slot);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (typed_results.size() != 0) begin
                    if (typed_results[0] != exp_r) begin
                        $error("typed row exp %p got %p", typed_results[0], exp_r);
                        errors++;
                    end
                    void'(typed_results.pop_front());
                end
                if (o_data.status != exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_data.status); errors++;
                end
                if (o_data.timer_slot != exp_r.timer_slot) begin
                    $error("timer_slot exp %0d got %0d", exp_r.timer_slot,
                           o_data.timer_slot); errors++;
                end
                if (o_data.wait_ms != exp_r.wait_ms) begin
                    $error("wait_ms exp %0d got %0d", exp_r.wait_ms, o_data.wait_ms);
                    errors++;
                end
                if (o_data.queue_empty != exp_r.queue_empty) begin
                    $error("queue_empty exp %0d got %0d", exp_r.queue_empty,
                           o_data.queue_empty); errors++;
                end
                if (o_data.last != exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, o_data.last); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls, updated at the falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall);
    end

    // returns at the accepting edge; the next falling edge replaces or drops the item
    task automatic send_item(t_in it);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data  <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_timers(it);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_in mk_in(t_func f, logic [47:0] n, logic [31:0] d, bit p);
        t_in it;
        it.func = f;
        it.now_ms = n;
        it.delay_ms = d;
        it.periodic = p;
        return it;
    endfunction

    function automatic t_row mk_row(t_in it, bit known, t_out res);
        t_row r;
        r.item = it;
        r.known = known;
        r.res = res;
        return r;
    endfunction

    function automatic t_in random_item(logic [47:0] base);
        int pick;
        t_func f;
        logic [31:0] d;
        pick = $urandom_range(99);
        f = (pick < 45) ? FUNC_ADD : (pick < 75) ? FUNC_EXPIRE :
            (pick < 92) ? FUNC_QUERY : FUNC_STOP;
        case ($urandom_range(3))
            0: d = $urandom_range(20);
            1: d = $urandom_range(1000);
            2: d = $urandom;
            default: d = 32'hFFFF_FFFF;
        endcase
        if ($urandom_range(15) == 0) base = 48'({$urandom, $urandom});
        return mk_in(f, base, d, 1'($urandom_range(1)));
    endfunction

    initial begin
        t_row rows [$];
        logic [47:0] clock_ms;
        foreach (busy_q[i]) begin
            busy_q[i] = 0;
            repeat_q[i] = 0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; expectations typed only where obvious
        rows.insert(rows.size(), mk_row(mk_in(FUNC_QUERY, TimeMax, '0, 1), 1,
                                        mk(ST_WAIT, 0, '0, 1, 1)));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_EXPIRE, '0, '0, 0), 1,
                                        mk(ST_NONE, 0, '0, 1, 1)));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_STOP, '0, '0, 0), 1,
                                        mk(ST_STOPPED, 0, '0, 1, 1)));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_ADD, TimeMax, 32'hFFFF_FFFF, 1), 1,
                                        mk(ST_ADDED, 0, '0, 0, 1)));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_ADD, 48'd100, 32'd0, 0), 1,
                                        mk(ST_ADDED, 1, '0, 0, 1)));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_QUERY, 48'd50, '0, 0), 1,
                                        mk(ST_WAIT, 0, 48'd50, 0, 1)));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_QUERY, 48'd500, '0, 0), 1,
                                        mk(ST_WAIT, 0, '0, 0, 1)));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_ADD, 48'd100, 32'd0, 1), 0, '0));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_EXPIRE, 48'd100, '0, 0), 0, '0));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_EXPIRE, 48'd100, '0, 0), 0, '0));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_STOP, 48'hAAAA_AAAA_AAAA,
                                              32'h5555_5555, 1), 0, '0));
        rows.insert(rows.size(), mk_row(mk_in(FUNC_EXPIRE, TimeMax, '0, 0), 0, '0));
        foreach (rows[k]) begin
            if (rows[k].known) typed_results.insert(typed_results.size(), rows[k].res);
            send_item(rows[k].item);
            drain_results();
        end

        // fill to full, then one more add reports full; expire all at once
        for (int i = 0; i < NumSlots + 1; i++)
            send_item(mk_in(FUNC_ADD, 48'd7, $urandom_range(3), i[0]));
        send_item(mk_in(FUNC_EXPIRE, 48'd20, '0, 0));
        send_item(mk_in(FUNC_STOP, 48'd20, '0, 0));
        send_item(mk_in(FUNC_EXPIRE, TimeMax, '0, 0));
        drain_results();

        // random part over idle phases
        clock_ms = 48'd1000;
        for (int ph = 0; ph < 5; ph++) begin
            sender_idle    = (ph == 1 || ph == 3) ? 64 : 0;
            receiver_stall = (ph == 2) ? 64 : (ph == 3) ? 26 : 0;
            if (ph == 3) sender_idle = 26;
            for (int n = 0; n < 26; n++) begin
                clock_ms = clock_ms + $urandom_range(40);
                send_item(random_item(clock_ms));
                if (ph == 4 && n == 10) drain_results();
            end
            drain_results();
        end

        repeat (NumSlots * 4) @(negedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
